>>> hdl/fssm_pkg.sv
`default_nettype none

package fssm_pkg;

    localparam int MAX_PATTERN_DEF   = 16;
    localparam int POSITION_BITS_DEF = 32;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 64;
    localparam int LEN_W      = 5;
    localparam int MATCH_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int PAT_BYTES  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] t_pattern;

    // Status from the window compare back to the control path.
    typedef struct packed {
        logic             hit;
        logic [LEN_W-1:0] eff_len;
    } t_match_info;

endpackage

`default_nettype wire

>>> hdl/fssm_if.sv
`default_nettype none

interface fssm_byte_if;
    import fssm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface fssm_result_if;
    import fssm_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [MATCH_W-1:0] match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink   (input valid, input found, input match_position, output ready);
endinterface

interface fssm_cfg_if;
    import fssm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/fssm_match.sv
`default_nettype none

module fssm_match #(
    parameter int MAX_PATTERN = fssm_pkg::MAX_PATTERN_DEF
) (
    input  fssm_pkg::t_pattern                            i_pattern,
    input  logic [fssm_pkg::LEN_W-1:0]                    i_length,
    input  logic [MAX_PATTERN-1:0][fssm_pkg::BYTE_W-1:0]  i_window,
    output fssm_pkg::t_match_info                         o_info
);
    import fssm_pkg::*;

    logic [LEN_W-1:0] clamped;
    logic [LEN_W-1:0] eff_len;
    logic             hit;

    // Clamp the length, then cut the pattern at its first zero byte.
    always_comb begin
        if (i_length > LEN_W'(MAX_PATTERN)) begin
            clamped = LEN_W'(MAX_PATTERN);
        end else begin
            clamped = i_length;
        end
        eff_len = clamped;
        for (int i = MAX_PATTERN - 1; i >= 0; i--) begin
            if ((LEN_W'(i) < clamped) && (i_pattern[i] == '0)) begin
                eff_len = LEN_W'(i);
            end
        end
    end

    // One compare set per candidate length; window entry 0 is the newest byte.
    always_comb begin
        logic ok;
        hit = 1'b0;
        for (int l = 1; l <= MAX_PATTERN; l++) begin
            ok = 1'b1;
            for (int i = 0; i < l; i++) begin
                if (i_pattern[i] != i_window[l-1-i]) begin
                    ok = 1'b0;
                end
            end
            if (eff_len == LEN_W'(l)) begin
                hit = ok;
            end
        end
    end

    assign o_info.hit     = hit;
    assign o_info.eff_len = eff_len;

endmodule

`default_nettype wire

>>> hdl/first_substring_match_search.sv
`default_nettype none

// First-match substring search (strstr semantics) over a zero-terminated
// byte stream. Program the pattern through the config channel: register 0
// holds pattern bytes 0..7, register 1 bytes 8..15 (byte 0 in the low bits),
// register 2 the length; the pattern also ends at its first zero byte and a
// length above MAX_PATTERN counts as MAX_PATTERN. Write config only while the
// block is idle. Each input beat is one byte of the string; a zero byte ends
// the string and restarts the search. Exactly one result beat per string:
// found=1 with the start offset when the first match completes (later bytes
// of that string give nothing), or found=0, position 0, on the terminator.
// An empty pattern reports a match at offset 0 on the first byte. Offsets
// saturate at 2^POSITION_BITS-1 and at 2^32-1. The block takes one byte per
// cycle while results are taken; a result beat passes the input register,
// then the result register, before it is presented on the output. A result
// that waits for ready holds the byte behind it in the input register. The
// rate is set by the parallel window compare, which evaluates every pattern
// position combinationally.
module first_substring_match_search #(
    parameter int MAX_PATTERN   = fssm_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = fssm_pkg::POSITION_BITS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    fssm_cfg_if.sink       i_cfg,
    fssm_byte_if.sink      i_in,
    fssm_result_if.source  o_out
);
    import fssm_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam int EXT_W = (POSITION_BITS > MATCH_W) ? POSITION_BITS : MATCH_W;

    // Config registers.
    logic [WORD_W-1:0] r_pat_low;
    logic [WORD_W-1:0] r_pat_high;
    logic [LEN_W-1:0]  r_pat_len;

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Search state.
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] r_win, n_win;
    logic [POSITION_BITS-1:0]           r_pos, n_pos;
    logic                               r_done;

    // Result register.
    logic               r_out_valid;
    logic               r_out_found;
    logic [MATCH_W-1:0] r_out_pos;

    logic               advance;
    logic               emit;
    logic               emit_found;
    logic [MATCH_W-1:0] emit_pos;
    logic               n_done;
    logic               restart;
    logic               take_byte;
    logic [EXT_W-1:0]   pos_ext;
    logic [POSITION_BITS-1:0] start_pos;
    t_match_info        info;

    assign i_cfg.ready = 1'b1;

    // Move the input beat forward whenever the result slot is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Shift the new byte into the window and bump the saturating offset.
    always_comb begin
        n_win[0] = r_in_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = r_win[k-1];
        end
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    end

    fssm_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .i_pattern (t_pattern'({r_pat_high, r_pat_low})),
        .i_length  (r_pat_len),
        .i_window  (n_win),
        .o_info    (info)
    );

    // Start offset of a match ending at this byte, saturated twice over.
    always_comb begin
        if (n_pos == POS_MAX) begin
            start_pos = POS_MAX;
        end else if (n_pos >= POSITION_BITS'(info.eff_len)) begin
            start_pos = n_pos - POSITION_BITS'(info.eff_len);
        end else begin
            start_pos = '0;
        end
        pos_ext = EXT_W'(start_pos);
    end

    // Decide what this byte does: restart, update the search, emit a result, or nothing.
    always_comb begin
        emit       = 1'b0;
        emit_found = 1'b0;
        emit_pos   = '0;
        n_done     = r_done;
        restart    = 1'b0;
        take_byte  = 1'b0;
        if (r_in_byte == '0) begin
            // Terminator: report not-found (or the empty-pattern hit) once.
            emit       = !r_done;
            emit_found = (info.eff_len == '0);
            restart    = 1'b1;
            n_done     = 1'b0;
        end else if (!r_done) begin
            take_byte = 1'b1;
            if (info.eff_len == '0) begin
                emit       = 1'b1;
                emit_found = 1'b1;
                n_done     = 1'b1;
            end else if (info.hit) begin
                emit       = 1'b1;
                emit_found = 1'b1;
                n_done     = 1'b1;
                if (pos_ext > EXT_W'({MATCH_W{1'b1}})) begin
                    emit_pos = {MATCH_W{1'b1}};
                end else begin
                    emit_pos = pos_ext[MATCH_W-1:0];
                end
            end
        end
    end

    // Config writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PATTERN_LOW:  r_pat_low  <= i_cfg.data;
                REG_PATTERN_HIGH: r_pat_high <= i_cfg.data;
                REG_PATTERN_LEN:  r_pat_len  <= i_cfg.data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the byte until the search stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.stream_byte;
        end
    end

    // Search state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_pos  <= '0;
            r_done <= 1'b0;
        end else if (advance) begin
            r_done <= n_done;
            if (restart) begin
                r_win <= '0;
                r_pos <= '0;
            end else if (take_byte) begin
                r_win <= n_win;
                r_pos <= n_pos;
            end
        end
    end

    // Result register: load on a result, drop the beat once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_found <= emit_found;
            r_out_pos   <= emit_pos;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.found          = r_out_found;
    assign o_out.match_position = r_out_pos;

    // A not-found result always carries offset zero.
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.found |-> o_out.match_position == '0)
        else $error("not-found result with nonzero position");

    // A result from a data byte closes the string.
    a_done_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && emit && (r_in_byte != '0) |=> r_done)
        else $error("search not closed after match");

    // No second result within one string.
    a_one_per_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_done && (r_in_byte != '0) |-> !emit)
        else $error("second result in one string");

    // A full pipe with a stalled sink refuses new bytes.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !o_out.ready |-> !i_in.ready)
        else $error("byte accepted while pipe is stalled");

endmodule

`default_nettype wire

>>> verif/first_substring_match_search_tb.sv
module first_substring_match_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fssm_pkg::*;

    // Result beat as the monitor sees it.
    typedef struct packed {
        logic               found;
        logic [MATCH_W-1:0] position;
    } t_match_result;

    // Positions saturate at the top of the counter range.
    localparam longint unsigned POS_LIMIT = (64'd1 << POSITION_BITS_DEF) - 64'd1;
    localparam int WIN_DEPTH = PAT_BYTES;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    fssm_cfg_if    cfg_if();
    fssm_byte_if   byte_if();
    fssm_result_if result_if();

    first_substring_match_search u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (byte_if),
        .o_out   (result_if)
    );

    // 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Search predictor: its own copy of the pattern registers, the window
    // of recent bytes, the byte count and the done flag.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] pat_lo;
    logic [WORD_W-1:0] pat_hi;
    logic [LEN_W-1:0]  pat_len;
    logic [BYTE_W-1:0] recent_win [WIN_DEPTH];
    longint unsigned   scan_pos;
    bit                hit_done;

    t_match_result     pending_results [$];  // expected result beats, oldest first
    logic [BYTE_W-1:0] stream_q [$];         // bytes still to be offered
    logic [BYTE_W-1:0] phase_bytes [$];      // bytes of the phase being built
    logic [BYTE_W-1:0] sym_pool [$];         // alphabet of the phase; empty means any

    int          mismatches   = 0;
    bit          no_idle      = 1'b0;        // stretch with no gaps on either side
    bit          src_pause    = 1'b0;        // sender stops offering new bytes
    bit          hold_request = 1'b0;        // ask for one long receiver hold-off
    int unsigned rx_hold_left = 0;
    int          tx_gap       = 0;
    int          rx_gap       = 0;

    function automatic logic [BYTE_W-1:0] pattern_at(input int i);
        if (i < 8) begin
            return pat_lo[8*i +: 8];
        end
        return pat_hi[8*(i-8) +: 8];
    endfunction

    // Length in use: capped at the maximum, cut at the first zero byte.
    function automatic int active_length();
        int lim;
        lim = (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
        for (int i = 0; i < lim; i++) begin
            if (pattern_at(i) == 8'h00) begin
                return i;
            end
        end
        return lim;
    endfunction

    task automatic restart_scan();
        for (int k = 0; k < WIN_DEPTH; k++) begin
            recent_win[k] = 8'h00;
        end
        scan_pos = 0;
        hit_done = 1'b0;
    endtask

    // Advance the predictor by one accepted byte and queue what it yields.
    task automatic scan_byte(input logic [BYTE_W-1:0] b);
        int              len;
        bit              hit;
        longint unsigned start;
        t_match_result   r;
        len = active_length();
        if (b == 8'h00) begin
            // Terminator: report not found unless the string already reported.
            if (!hit_done) begin
                r.found    = (len == 0);
                r.position = '0;
                pending_results.push_back(r);
            end
            restart_scan();
            return;
        end
        if (hit_done) begin
            return;
        end
        for (int k = WIN_DEPTH - 1; k > 0; k--) begin
            recent_win[k] = recent_win[k-1];
        end
        recent_win[0] = b;
        if (scan_pos < POS_LIMIT) begin
            scan_pos++;
        end
        // Empty pattern matches on the first byte.
        if (len == 0) begin
            hit_done   = 1'b1;
            r.found    = 1'b1;
            r.position = '0;
            pending_results.push_back(r);
            return;
        end
        hit = 1'b1;
        for (int i = 0; i < len; i++) begin
            if (pattern_at(i) != recent_win[(len - 1 - i) & (WIN_DEPTH - 1)]) begin
                hit = 1'b0;
            end
        end
        if (!hit) begin
            return;
        end
        hit_done = 1'b1;
        if (scan_pos >= POS_LIMIT) begin
            start = POS_LIMIT;
        end else if (scan_pos >= longint'(len)) begin
            start = scan_pos - len;
        end else begin
            start = 0;
        end
        if (start > 64'hFFFF_FFFF) begin
            start = 64'hFFFF_FFFF;
        end
        r.found    = 1'b1;
        r.position = start[MATCH_W-1:0];
        pending_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        $display("[%0t] mismatch, %s: expected %0h, got %0h", $realtime, what, want, got);
        mismatches++;
    endtask

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_symbol();
        if (sym_pool.size() == 0) begin
            return 8'($urandom_range(1, 255));
        end
        return sym_pool[$urandom_range(0, sym_pool.size() - 1)];
    endfunction

    // Mostly short strings, a few long ones.
    function automatic int pick_run();
        if ($urandom_range(0, 99) < 3) begin
            return $urandom_range(100, 300);
        end
        return $urandom_range(0, 10);
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: offer the head of stream_q, hold it until accepted,
    // then advance. The predictor sees each byte at its acceptance edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            byte_if.valid       <= 1'b0;
            byte_if.stream_byte <= '0;
            tx_gap = 0;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                scan_byte(byte_if.stream_byte);
                stream_q.delete(0);
                tx_gap = idle_gap();
            end
            // A beat still waiting for ready stays put; otherwise pick the next step.
            if (!(byte_if.valid && !byte_if.ready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    byte_if.valid <= 1'b0;
                end else if (src_pause || stream_q.size() == 0) begin
                    byte_if.valid <= 1'b0;
                end else begin
                    byte_if.valid       <= 1'b1;
                    byte_if.stream_byte <= stream_q[0];
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the monitor only looks at the count.
    always @(posedge i_clk) begin : rx_hold_timer
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (hold_request) begin
            rx_hold_left <= 500;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted result beat against the oldest
    // expectation, field by field, and drive ready with random gaps.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_match_result want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", 0,
                                    {result_if.found, result_if.match_position});
                end else begin
                    want = pending_results.pop_front();
                    if (result_if.found !== want.found) begin
                        report_mismatch("found", want.found, result_if.found);
                    end
                    if (result_if.match_position !== want.position) begin
                        report_mismatch("match_position", want.position,
                                        result_if.match_position);
                    end
                end
                rx_gap = idle_gap();
            end
            if (rx_hold_left != 0) begin
                result_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Write one register through the config channel; update the predictor
    // at the handshake edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:  pat_lo  = value;
            REG_PATTERN_HIGH: pat_hi  = value;
            REG_PATTERN_LEN:  pat_len = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every byte is taken and every result is back, then let the
    // pipeline drain bytes that produce nothing.
    task automatic wait_drained();
        do @(negedge i_clk); while (stream_q.size() != 0 || pending_results.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // Hand the built phase to the driver, apply the requested pressure, drain.
    task automatic run_phase(input bit do_hold, input bit do_pause);
        @(negedge i_clk);
        stream_q = phase_bytes;
        if (do_hold) begin
            hold_request = 1'b1;
            do @(negedge i_clk); while (rx_hold_left == 0);
            hold_request = 1'b0;
        end
        if (do_pause) begin
            repeat ($urandom_range(5, 30)) @(negedge i_clk);
            src_pause = 1'b1;
            do @(negedge i_clk); while (byte_if.valid || pending_results.size() != 0);
            src_pause = 1'b0;
        end
        wait_drained();
    endtask

    // New alphabet and pattern for a phase; write each register or keep it.
    task automatic choose_config(input bit write_all);
        logic [BYTE_W-1:0] pbytes [PAT_BYTES];
        logic [WORD_W-1:0] lo_val;
        logic [WORD_W-1:0] hi_val;
        logic [WORD_W-1:0] len_val;
        int                r;
        int                len_pick;
        int                n_sym;
        sym_pool.delete();
        if ($urandom_range(0, 3) != 0) begin
            n_sym = $urandom_range(2, 4);
            repeat (n_sym) sym_pool.push_back(8'($urandom_range(1, 255)));
        end
        for (int i = 0; i < PAT_BYTES; i++) begin
            pbytes[i] = pick_symbol();
        end
        // Now and then a zero byte cuts the pattern short.
        if ($urandom_range(0, 11) == 0) begin
            pbytes[$urandom_range(0, PAT_BYTES - 1)] = 8'h00;
        end
        for (int i = 0; i < 8; i++) begin
            lo_val[8*i +: 8] = pbytes[i];
            hi_val[8*i +: 8] = pbytes[i+8];
        end
        if ($urandom_range(0, 9) == 0) begin
            lo_val = {$urandom, $urandom};
        end
        if ($urandom_range(0, 9) == 0) begin
            hi_val = {$urandom, $urandom};
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            len_pick = 0;
        end else if (r < 20) begin
            len_pick = MAX_PATTERN_DEF;
        end else if (r < 26) begin
            len_pick = $urandom_range(MAX_PATTERN_DEF + 1, 31);
        end else if (r < 36) begin
            len_pick = 1;
        end else if (r < 50) begin
            len_pick = $urandom_range(9, 15);
        end else begin
            len_pick = $urandom_range(2, 8);
        end
        len_val = '0;
        if ($urandom_range(0, 3) == 0) begin
            len_val = {$urandom, $urandom};
        end
        len_val[LEN_W-1:0] = len_pick[LEN_W-1:0];
        if (write_all || $urandom_range(0, 3) != 0) begin
            write_reg(REG_PATTERN_LOW, lo_val);
        end
        if (write_all || $urandom_range(0, 3) != 0) begin
            write_reg(REG_PATTERN_HIGH, hi_val);
        end
        if (write_all || $urandom_range(0, 3) != 0) begin
            write_reg(REG_PATTERN_LEN, len_val);
        end
    endtask

    // Append one string: mostly a planted match, else plain text, a near
    // miss, or raw noise with no terminator.
    task automatic add_string();
        int kind;
        int plen;
        int k;
        plen = active_length();
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            repeat (pick_run()) phase_bytes.push_back(pick_symbol());
            for (int i = 0; i < plen; i++) begin
                phase_bytes.push_back(pattern_at(i));
            end
            repeat ($urandom_range(0, 6)) phase_bytes.push_back(pick_symbol());
            phase_bytes.push_back(8'h00);
        end else if (kind < 80) begin
            repeat (pick_run()) phase_bytes.push_back(pick_symbol());
            phase_bytes.push_back(8'h00);
        end else if (kind < 90) begin
            k = (plen > 1) ? $urandom_range(1, plen - 1) : 0;
            repeat ($urandom_range(0, 4)) phase_bytes.push_back(pick_symbol());
            for (int i = 0; i < k; i++) begin
                phase_bytes.push_back(pattern_at(i));
            end
            repeat ($urandom_range(1, 6)) phase_bytes.push_back(pick_symbol());
            phase_bytes.push_back(8'h00);
        end else begin
            repeat ($urandom_range(1, 8)) phase_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int random_sent;
        int phase_no;
        int target;
        // Known values on the config inputs from time zero.
        cfg_if.valid        = 1'b0;
        cfg_if.index        = REG_PATTERN_LOW;
        cfg_if.data         = '0;
        pat_lo  = '0;
        pat_hi  = '0;
        pat_len = '0;
        restart_scan();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Empty pattern out of reset: the terminator as first byte matches,
        // then a first byte matches and the rest of that string is quiet.
        phase_bytes = '{8'h00, 8'h01, 8'hFF, 8'h00};
        run_phase(1'b0, 1'b0);

        // Zero byte inside the pattern: "ab" with a length of five.
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_0000_6261);
        write_reg(REG_PATTERN_LEN, 64'd5);
        phase_bytes = '{8'h61, 8'h62, 8'h00};
        run_phase(1'b0, 1'b0);

        // All-ones pattern, length above the maximum; no match.
        write_reg(REG_PATTERN_LOW,  64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PATTERN_LEN,  64'd31);
        phase_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'h00};
        run_phase(1'b0, 1'b0);

        // Overlapping "aba" at offset two, then start a new string and leave
        // it open for the pattern change.
        write_reg(REG_PATTERN_LOW,  64'h0000_0000_0061_6261);
        write_reg(REG_PATTERN_HIGH, 64'h0);
        write_reg(REG_PATTERN_LEN,  64'd3);
        phase_bytes = '{8'h78, 8'h78, 8'h61, 8'h62, 8'h61, 8'h00, 8'h71, 8'h7A};
        run_phase(1'b0, 1'b0);

        // Pattern changed mid-string: "zw" must see the 'z' already held.
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_0000_777A);
        write_reg(REG_PATTERN_LEN, 64'd2);
        phase_bytes = '{8'h77, 8'h00};
        run_phase(1'b0, 1'b0);

        // Random phases. Phase 3 holds the receiver off with a one-byte
        // pattern so results pile up; phase 6 pauses the sender mid-stream.
        random_sent = 0;
        phase_no    = 0;
        while (random_sent < 1400) begin
            choose_config(phase_no == 0);
            if (phase_no == 3) begin
                write_reg(REG_PATTERN_LEN, 64'd1);
            end
            no_idle = (phase_no % 5 == 4);
            phase_bytes.delete();
            target = $urandom_range(30, 90);
            while (phase_bytes.size() < target) begin
                add_string();
            end
            run_phase(phase_no == 3, phase_no == 6);
            random_sent += phase_bytes.size();
            phase_no++;
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin : watchdog
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> first_substring_match_search.f
hdl/fssm_pkg.sv
hdl/fssm_if.sv
hdl/fssm_match.sv
hdl/first_substring_match_search.sv
verif/first_substring_match_search_tb.sv
